/* hw/rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ARC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked during reset as well
`define ARC_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* hw/rtl/arc_pkg.sv */
package arc_pkg;

  localparam int unsigned MaxExcludes = 16;
  localparam int unsigned IdxW = (MaxExcludes > 1) ? $clog2(MaxExcludes) : 1;
  localparam int unsigned CntW = $clog2(MaxExcludes + 1);
  localparam int unsigned AddrW = 32;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [AddrW-1:0] WindowLowReset = 32'h8000_0000;
  localparam logic [AddrW-1:0] WindowHighReset = 32'h8180_0000;

  typedef enum logic [1:0] {
    ModeClear,
    ModeAdd,
    ModeCarve,
    ModeNone
  } mode_e;

  typedef enum logic [1:0] {
    StatusOk,
    StatusFull,
    StatusBadRange
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWindowLow,
    CfgWindowHigh
  } cfg_reg_e;

  typedef enum logic [2:0] {
    StIdle,
    StEval,
    StAdd,
    StCarve,
    StTail,
    StFin
  } state_e;

  typedef struct packed {
    logic             en;
    logic [IdxW-1:0]  idx;
    logic [AddrW-1:0] range_start;
    logic [AddrW-1:0] range_end;
  } tbl_wr_t;

endpackage

/* hw/rtl/arc_if.sv */
interface arc_req_if;
  import arc_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       mode;
  logic [AddrW-1:0] range_start;
  logic [AddrW-1:0] range_end;

  modport source (output valid, output mode, output range_start, output range_end,
                  input ready);
  modport sink (input valid, input mode, input range_start, input range_end,
                output ready);
endinterface

interface arc_rsp_if;
  import arc_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [AddrW-1:0] span_start;
  logic [AddrW-1:0] span_end;
  logic             span_valid;
  logic             last;

  modport source (output valid, output status, output span_start, output span_end,
                  output span_valid, output last, input ready);
  modport sink (input valid, input status, input span_start, input span_end,
                input span_valid, input last, output ready);
endinterface

/* hw/rtl/arc_table.sv */
module arc_table (
  input  logic                      clk_i,
  input  arc_pkg::tbl_wr_t          wr_i,
  input  logic [arc_pkg::IdxW-1:0]  rd_idx_i,
  output logic [arc_pkg::AddrW-1:0] rd_start_o,
  output logic [arc_pkg::AddrW-1:0] rd_end_o
);
  import arc_pkg::*;

  logic [AddrW-1:0] starts_q [MaxExcludes];
  logic [AddrW-1:0] ends_q   [MaxExcludes];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      starts_q[wr_i.idx] <= wr_i.range_start;
      ends_q[wr_i.idx]   <= wr_i.range_end;
    end
  end

  assign rd_start_o = starts_q[rd_idx_i];
  assign rd_end_o   = ends_q[rd_idx_i];

endmodule

/* hw/rtl/address_range_carver.sv */
// address_range_carver
// Keeps up to MaxExcludes exclusion ranges sorted by start address and
// carves regions against them.
// req_i: one request per handshake, mode clear, add or carve, with an
// address range [range_start, range_end). Mode three is dropped silently.
// rsp_o: result items; clear, add and rejected requests give one, carve
// one per leftover sub-span (last on the final one) or a single empty result.
// cfg_we_i/cfg_idx_i/cfg_data_i: window_low and window_high, written idle.
// Timing: a request is taken in the idle state, evaluated the next cycle.
// Clear and rejected requests finish in evaluation once the output is free.
// An add shifts the table one entry a cycle past each entry above the new
// start, then writes the new entry once the output is free. A carve walks
// one table entry a cycle through a single compare unit while not stalled,
// then the tail and final results; one result leaves per cycle at most.
// A pending span register and the output register hold two results; a
// stalled receiver stops the walk when a third result is found. The next
// request is taken while the last result of the previous one still waits.
// Reset clears the table count, the output register and sets the window to
// 0x80000000 .. 0x81800000. The table contents need no reset.
`include "assert_macros.svh"

module address_range_carver (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  arc_req_if.sink                     req_i,
  arc_rsp_if.source                   rsp_o,
  input  logic                        cfg_we_i,
  input  logic [arc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [arc_pkg::AddrW-1:0]   cfg_data_i
);
  import arc_pkg::*;

  state_e           state_q, state_d;
  mode_e            mode_q, mode_d;
  logic [AddrW-1:0] s_q, s_d, e_q, e_d;
  logic [AddrW-1:0] win_lo_q, win_hi_q;
  logic [CntW-1:0]  excl_count_q, excl_count_d;
  logic [IdxW-1:0]  pos_q, pos_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [AddrW-1:0] cursor_q, cursor_d;
  logic             pend_v_q, pend_v_d;
  logic [AddrW-1:0] pend_s_q, pend_s_d, pend_e_q, pend_e_d;

  logic             out_valid_q, out_valid_d;
  status_e          out_status_q, out_status_d;
  logic [AddrW-1:0] out_s_q, out_s_d, out_e_q, out_e_d;
  logic             out_sv_q, out_sv_d, out_last_q, out_last_d;

  logic             out_free, push, push_sv, push_last;
  status_e          push_status;
  logic [AddrW-1:0] push_s, push_e;
  logic             good, skip, gap;
  logic             in_walk;

  tbl_wr_t          tbl_wr;
  logic [IdxW-1:0]  rd_idx;
  logic [AddrW-1:0] rd_start, rd_end;

  arc_table u_table (
    .clk_i      (clk_i),
    .wr_i       (tbl_wr),
    .rd_idx_i   (rd_idx),
    .rd_start_o (rd_start),
    .rd_end_o   (rd_end)
  );

  assign out_free = !out_valid_q || rsp_o.ready;
  assign good     = (s_q >= win_lo_q) && (e_q <= win_hi_q) && (s_q < e_q);
  assign skip     = (rd_end <= cursor_q) || (rd_start >= e_q);
  assign gap      = !skip && (rd_start > cursor_q);
  assign rd_idx   = (state_q == StAdd) ? (pos_q - IdxW'(1)) : idx_q[IdxW-1:0];
  assign in_walk  = (state_q == StCarve) || (state_q == StTail) || (state_q == StFin);

  assign req_i.ready = (state_q == StIdle);

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    s_d          = s_q;
    e_d          = e_q;
    excl_count_d = excl_count_q;
    pos_d        = pos_q;
    idx_d        = idx_q;
    cursor_d     = cursor_q;
    pend_v_d     = pend_v_q;
    pend_s_d     = pend_s_q;
    pend_e_d     = pend_e_q;
    push         = 1'b0;
    push_status  = StatusOk;
    push_s       = '0;
    push_e       = '0;
    push_sv      = 1'b0;
    push_last    = 1'b1;
    tbl_wr       = '0;

    unique case (state_q)
      StIdle: begin
        if (req_i.valid) begin
          mode_d  = mode_e'(req_i.mode);
          s_d     = req_i.range_start;
          e_d     = req_i.range_end;
          state_d = StEval;
        end
      end
      StEval: begin
        unique case (mode_q)
          ModeNone: state_d = StIdle;
          ModeClear: begin
            if (out_free) begin
              push         = 1'b1;
              excl_count_d = '0;
              state_d      = StIdle;
            end
          end
          ModeAdd, ModeCarve: begin
            if (!good) begin
              if (out_free) begin
                push        = 1'b1;
                push_status = StatusBadRange;
                state_d     = StIdle;
              end
            end else if (mode_q == ModeCarve) begin
              cursor_d = s_q;
              idx_d    = '0;
              pend_v_d = 1'b0;
              state_d  = StCarve;
            end else if (excl_count_q >= CntW'(MaxExcludes)) begin
              if (out_free) begin
                push        = 1'b1;
                push_status = StatusFull;
                state_d     = StIdle;
              end
            end else begin
              pos_d   = excl_count_q[IdxW-1:0];
              state_d = StAdd;
            end
          end
        endcase
      end
      StAdd: begin
        if (pos_q != '0 && rd_start > s_q) begin
          tbl_wr = '{en: 1'b1, idx: pos_q, range_start: rd_start, range_end: rd_end};
          pos_d  = pos_q - IdxW'(1);
        end else if (out_free) begin
          tbl_wr       = '{en: 1'b1, idx: pos_q, range_start: s_q, range_end: e_q};
          excl_count_d = excl_count_q + CntW'(1);
          push         = 1'b1;
          state_d      = StIdle;
        end
      end
      StCarve: begin
        if (idx_q < excl_count_q && cursor_q < e_q) begin
          if (!(gap && pend_v_q && !out_free)) begin
            if (gap) begin
              push      = pend_v_q;
              push_s    = pend_s_q;
              push_e    = pend_e_q;
              push_sv   = 1'b1;
              push_last = 1'b0;
              pend_v_d  = 1'b1;
              pend_s_d  = cursor_q;
              pend_e_d  = rd_start;
            end
            if (!skip && rd_end > cursor_q) begin
              cursor_d = rd_end;
            end
            idx_d = idx_q + CntW'(1);
          end
        end else begin
          state_d = StTail;
        end
      end
      StTail: begin
        if (cursor_q < e_q) begin
          if (!(pend_v_q && !out_free)) begin
            push      = pend_v_q;
            push_s    = pend_s_q;
            push_e    = pend_e_q;
            push_sv   = 1'b1;
            push_last = 1'b0;
            pend_v_d  = 1'b1;
            pend_s_d  = cursor_q;
            pend_e_d  = e_q;
            state_d   = StFin;
          end
        end else begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (out_free) begin
          push     = 1'b1;
          push_sv  = pend_v_q;
          push_s   = pend_v_q ? pend_s_q : '0;
          push_e   = pend_v_q ? pend_e_q : '0;
          pend_v_d = 1'b0;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_s_d      = out_s_q;
    out_e_d      = out_e_q;
    out_sv_d     = out_sv_q;
    out_last_d   = out_last_q;
    if (push) begin
      out_valid_d  = 1'b1;
      out_status_d = push_status;
      out_s_d      = push_s;
      out_e_d      = push_e;
      out_sv_d     = push_sv;
      out_last_d   = push_last;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      excl_count_q <= '0;
      pend_v_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      win_lo_q     <= WindowLowReset;
      win_hi_q     <= WindowHighReset;
    end else begin
      state_q      <= state_d;
      excl_count_q <= excl_count_d;
      pend_v_q     <= pend_v_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          CfgWindowLow:  win_lo_q <= cfg_data_i;
          CfgWindowHigh: win_hi_q <= cfg_data_i;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    s_q          <= s_d;
    e_q          <= e_d;
    pos_q        <= pos_d;
    idx_q        <= idx_d;
    cursor_q     <= cursor_d;
    pend_s_q     <= pend_s_d;
    pend_e_q     <= pend_e_d;
    out_status_q <= out_status_d;
    out_s_q      <= out_s_d;
    out_e_q      <= out_e_d;
    out_sv_q     <= out_sv_d;
    out_last_q   <= out_last_d;
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.span_start = out_s_q;
  assign rsp_o.span_end   = out_e_q;
  assign rsp_o.span_valid = out_sv_q;
  assign rsp_o.last       = out_last_q;

  `ARC_ASSERT(a_count_bound, excl_count_q <= CntW'(MaxExcludes), "exclusion count overflow")
  `ARC_ASSERT(a_add_room, (state_q == StAdd) |-> excl_count_q < CntW'(MaxExcludes), "table full")
  `ARC_ASSERT(a_push_free, push |-> out_free, "result overwrites a waiting result")
  `ARC_ASSERT(a_pend_carve, pend_v_q |-> in_walk, "pending span outside carve")
  `ARC_ASSERT_RST(a_reset_idle, !rst_ni |=> (state_q == StIdle && !out_valid_q), "busy in reset")

endmodule

/* bench/carve_sb_pkg.sv */
package carve_sb_pkg;
  import arc_pkg::*;

  typedef struct packed {
    status_e          status;
    logic [AddrW-1:0] span_start;
    logic [AddrW-1:0] span_end;
    logic             span_valid;
    logic             last;
  } span_rsp_t;

  class carve_scoreboard;
    logic [AddrW-1:0] win_lo;
    logic [AddrW-1:0] win_hi;
    logic [AddrW-1:0] x_start [MaxExcludes];
    logic [AddrW-1:0] x_end [MaxExcludes];
    int unsigned      n_excl;
    span_rsp_t        spans_q[$];
    int unsigned      errors;
    int unsigned      checked;
    int unsigned      full_hits;
    int unsigned      bad_hits;
    int unsigned      widest;

    function new();
      win_lo    = WindowLowReset;
      win_hi    = WindowHighReset;
      n_excl    = 0;
      errors    = 0;
      checked   = 0;
      full_hits = 0;
      bad_hits  = 0;
      widest    = 0;
    endfunction

    function void set_window(logic [AddrW-1:0] lo, logic [AddrW-1:0] hi);
      win_lo = lo;
      win_hi = hi;
    endfunction

    function int unsigned pending();
      return spans_q.size();
    endfunction

    function void push(status_e st, logic [AddrW-1:0] s, logic [AddrW-1:0] e, logic v,
                       logic l);
      span_rsp_t r;
      r.status     = st;
      r.span_start = s;
      r.span_end   = e;
      r.span_valid = v;
      r.last       = l;
      spans_q.insert(spans_q.size(), r);
    endfunction

    // interval subtraction of the sorted exclusions from [s, e)
    function void carve(logic [AddrW-1:0] s, logic [AddrW-1:0] e);
      logic [AddrW-1:0] cursor;
      int unsigned      n;
      int               i;
      cursor = s;
      n = 0;
      for (i = 0; i < n_excl; i++) begin
        if (x_end[i] <= cursor || x_start[i] >= e) continue;
        if (x_start[i] > cursor) begin
          push(StatusOk, cursor, x_start[i], 1'b1, 1'b0);
          n++;
        end
        if (x_end[i] > cursor) cursor = x_end[i];
        if (cursor >= e) break;
      end
      if (cursor < e) begin
        push(StatusOk, cursor, e, 1'b1, 1'b0);
        n++;
      end
      if (n == 0) push(StatusOk, '0, '0, 1'b0, 1'b1);
      else spans_q[spans_q.size() - 1].last = 1'b1;
      if (n > widest) widest = n;
    endfunction

    function void note_request(mode_e m, logic [AddrW-1:0] s, logic [AddrW-1:0] e);
      int unsigned pos;
      int unsigned i;
      if (m == ModeNone) return;
      if (m == ModeClear) begin
        n_excl = 0;
        push(StatusOk, '0, '0, 1'b0, 1'b1);
        return;
      end
      if (!(s >= win_lo && e <= win_hi && s < e)) begin
        bad_hits++;
        push(StatusBadRange, '0, '0, 1'b0, 1'b1);
        return;
      end
      if (m == ModeCarve) begin
        carve(s, e);
        return;
      end
      if (n_excl >= MaxExcludes) begin
        full_hits++;
        push(StatusFull, '0, '0, 1'b0, 1'b1);
        return;
      end
      // equal starts keep arrival order
      pos = n_excl;
      while (pos > 0 && x_start[pos-1] > s) pos--;
      for (i = n_excl; i > pos; i--) begin
        x_start[i] = x_start[i-1];
        x_end[i]   = x_end[i-1];
      end
      x_start[pos] = s;
      x_end[pos]   = e;
      n_excl++;
      push(StatusOk, '0, '0, 1'b0, 1'b1);
    endfunction

    function void report(string field, logic [AddrW-1:0] want, logic [AddrW-1:0] got,
                         longint at_ns);
      errors++;
      $display("%0d ns: %s mismatch, expected 0x%h actual 0x%h", at_ns, field, want, got);
    endfunction

    function void check_result(logic [1:0] status, logic [AddrW-1:0] s, logic [AddrW-1:0] e,
                               logic v, logic l, longint at_ns);
      span_rsp_t want;
      checked++;
      if (spans_q.size() == 0) begin
        errors++;
        $display("%0d ns: unexpected result, expected none actual status %0d span %h..%h",
                 at_ns, status, s, e);
        return;
      end
      want = spans_q[0];
      spans_q.delete(0);
      if (status !== want.status) begin
        report("status", AddrW'(want.status), AddrW'(status), at_ns);
      end
      if (s !== want.span_start) report("span_start", want.span_start, s, at_ns);
      if (e !== want.span_end) report("span_end", want.span_end, e, at_ns);
      if (v !== want.span_valid) begin
        report("span_valid", AddrW'(want.span_valid), AddrW'(v), at_ns);
      end
      if (l !== want.last) report("last", AddrW'(want.last), AddrW'(l), at_ns);
    endfunction
  endclass

endpackage

/* bench/tb_address_range_carver.sv */
module tb_address_range_carver;
  timeunit 1ns;
  timeprecision 1ps;

  import arc_pkg::*;
  import carve_sb_pkg::*;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  cfg_reg_e           cfg_idx;
  logic [AddrW-1:0]   cfg_data;
  bit                 steady;
  int unsigned        n_sent;
  logic [AddrW-1:0]   cluster;
  carve_scoreboard    sb;

  arc_req_if req ();
  arc_rsp_if rsp ();

  address_range_carver dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .rsp_o      (rsp),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp.valid && rsp.ready) begin
      sb.check_result(rsp.status, rsp.span_start, rsp.span_end, rsp.span_valid, rsp.last,
                      longint'($time));
    end
    rsp.ready <= steady || ($urandom_range(99) >= 27);
  end

  task automatic send(input mode_e m, input logic [AddrW-1:0] s, input logic [AddrW-1:0] e);
    if (!steady && $urandom_range(99) < 27) begin
      req.valid <= 1'b0;
      req.range_start <= $urandom;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    req.valid       <= 1'b1;
    req.mode        <= m;
    req.range_start <= s;
    req.range_end   <= e;
    do @(posedge clk_i); while (!req.ready);
    sb.note_request(m, s, e);
    if (m != ModeNone) n_sent++;
  endtask

  task automatic drain(input int settle);
    req.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic set_window(input logic [AddrW-1:0] lo, input logic [AddrW-1:0] hi);
    drain(24);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgWindowLow;
    cfg_data <= lo;
    @(posedge clk_i);
    cfg_idx  <= CfgWindowHigh;
    cfg_data <= hi;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    sb.set_window(lo, hi);
  endtask

  function automatic void new_cluster();
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned room;
    lo = 64'(sb.win_lo);
    hi = 64'(sb.win_hi);
    if (hi > lo + 96) begin
      room = hi - lo - 96;
      cluster = AddrW'(lo + ({$urandom, $urandom} % (room + 1)));
    end else begin
      cluster = AddrW'(lo);
    end
  endfunction

  // mostly near the current cluster so that ranges overlap and share starts
  function automatic logic [AddrW-1:0] pick_point();
    longint unsigned p;
    int              r;
    r = $urandom_range(99);
    if (r < 10) return $urandom;
    if (r < 13) return sb.win_lo;
    if (r < 16) return sb.win_hi;
    p = 64'(cluster) + 64'($urandom_range(0, 96));
    if (p > 64'(sb.win_hi)) p = 64'(sb.win_hi);
    return AddrW'(p);
  endfunction

  function automatic logic [AddrW-1:0] span_from(logic [AddrW-1:0] s, int unsigned len);
    return AddrW'(64'(s) + 64'($urandom_range(1, len)));
  endfunction

  task automatic send_noise();
    logic [1:0] mb;
    mb = 2'($urandom_range(3));
    send(mode_e'(mb), $urandom, $urandom);
  endtask

  task automatic run_episode();
    int               n_add;
    int               r;
    logic [AddrW-1:0] s;
    new_cluster();
    send(ModeClear, $urandom, $urandom);
    n_add = ($urandom_range(3) == 0) ? $urandom_range(15, 19) : $urandom_range(0, 8);
    repeat (n_add) begin
      s = pick_point();
      if ($urandom_range(99) < 85) send(ModeAdd, s, span_from(s, 24));
      else send(ModeAdd, s, pick_point());
    end
    repeat ($urandom_range(1, 4)) begin
      r = $urandom_range(99);
      s = pick_point();
      if (r < 15) send(ModeCarve, sb.win_lo, sb.win_hi);
      else if (r < 80) send(ModeCarve, s, span_from(s, 160));
      else if (r < 90) send(ModeCarve, s, pick_point());
      else send_noise();
    end
  endtask

  task automatic run_directed();
    logic [AddrW-1:0] base;
    logic [AddrW-1:0] s;
    int               j;
    base = WindowLowReset;
    send(ModeCarve, WindowLowReset, WindowHighReset);
    send(ModeAdd, base - 32'h10, base + 32'h10);
    send(ModeAdd, WindowHighReset - 32'h10, WindowHighReset + 32'h1);
    send(ModeAdd, base + 32'h400, base + 32'h400);
    send(ModeCarve, base + 32'h500, base + 32'h400);
    send(ModeNone, 32'hFFFF_FFFF, 32'h0);
    // sixteen disjoint exclusions in scrambled order
    for (int k = 0; k < MaxExcludes; k++) begin
      j = (k * 7) % MaxExcludes;
      s = base + j * 32'h1_0000 + 32'h100;
      send(ModeAdd, s, s + 32'h80);
    end
    send(ModeAdd, base, base + 32'h1);
    send(ModeCarve, WindowLowReset, WindowHighReset);
    send(ModeCarve, base + 32'h7_0100, base + 32'h7_0180);
    send(ModeCarve, base + 32'h3_0120, base + 32'h5_0110);
    send(ModeClear, 32'h0, 32'hFFFF_FFFF);
  endtask

  initial begin
    logic [AddrW-1:0] lo_tbl [7];
    logic [AddrW-1:0] hi_tbl [7];
    int unsigned      quota [7];
    int unsigned      goal;

    lo_tbl = '{32'h8000_0000, 32'h0000_0000, 32'h0000_1000, 32'hFFFF_FF00,
               32'h4000_0000, 32'h9000_0000, 32'h8000_0000};
    hi_tbl = '{32'h8180_0000, 32'hFFFF_FFFF, 32'h0000_1400, 32'hFFFF_FFFF,
               32'h4000_0000, 32'h1000_0000, 32'h8180_0000};
    quota  = '{70, 75, 70, 70, 15, 15, 105};

    sb              = new();
    steady          = 1'b0;
    n_sent          = 0;
    cluster         = '0;
    rst_ni          = 1'b0;
    req.valid       = 1'b0;
    req.mode        = ModeClear;
    req.range_start = '0;
    req.range_end   = '0;
    rsp.ready       = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = CfgWindowLow;
    cfg_data        = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    for (int p = 0; p < 7; p++) begin
      if (p > 0) set_window(lo_tbl[p], hi_tbl[p]);
      steady = (p == 2);
      goal = n_sent + quota[p];
      while (n_sent < goal) begin
        run_episode();
        // hold off until the block has emptied once
        if (p == 1 && n_sent >= goal - quota[p] / 2 && sb.pending() != 0 &&
            $urandom_range(9) == 0) begin
          drain(0);
        end
      end
    end
    steady = 1'b0;

    drain(40);
    $display("requests %0d, results checked %0d, table full %0d, bad range %0d",
             n_sent, sb.checked, sb.full_hits, sb.bad_hits);
    $display("widest carve %0d spans over 7 window settings incl. empty and inverted",
             sb.widest);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* address_range_carver.f */
+incdir+hw/rtl
hw/rtl/arc_pkg.sv
hw/rtl/arc_if.sv
hw/rtl/arc_table.sv
hw/rtl/address_range_carver.sv
bench/carve_sb_pkg.sv
bench/tb_address_range_carver.sv
